@@ rtl/pcs_pkg.sv @@
// Shared types, constants and helpers for the particle spring cursor step pipeline.
package pcs_pkg;

  // Field widths
  localparam int FIELD_W    = 24;
  localparam int DIFF_W     = FIELD_W + 1;
  localparam int RADIUS_W   = 10;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Square root unit: 36-bit radicand, 18-bit root, three root bits per stage
  localparam int SQ_IN_W   = 36;
  localparam int SQ_OUT_W  = SQ_IN_W / 2;
  localparam int SQ_STEPS  = 3;
  localparam int SQ_STAGES = SQ_OUT_W / SQ_STEPS;

  // Ratio divider: 16 quotient bits, four per stage
  localparam int QUO_W     = 16;
  localparam int DV_STEPS  = 4;
  localparam int DV_STAGES = QUO_W / DV_STEPS;

  // Cycles between the front end output and the back end input
  localparam int MID_LAT = SQ_STAGES + DV_STAGES;

  // Ratio is Q.16 and spans [-1, 1]
  localparam int RATIO_W = 18;
  localparam int SPR_W   = 27;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTRACTS    = 3'd0,
    CFG_RADIUS      = 3'd1,
    CFG_FRICTION    = 3'd2,
    CFG_SPRING_GAIN = 3'd3,
    CFG_SPRING_ON   = 3'd4
  } cfg_idx_t;

  // Per-item data that rides alongside the distance and ratio units
  typedef struct packed {
    logic                       in_radius;
    logic signed [FIELD_W-1:0]  pos_x;
    logic signed [FIELD_W-1:0]  pos_y;
    logic signed [DIFF_W-1:0]   d_x;
    logic signed [DIFF_W-1:0]   d_y;
    logic signed [DIFF_W-1:0]   v_x;
    logic signed [DIFF_W-1:0]   v_y;
    logic signed [SPR_W-1:0]    spr_x;
    logic signed [SPR_W-1:0]    spr_y;
  } side_t;

  // Clamp to the signed 24-bit range
  function automatic logic signed [FIELD_W-1:0] sat24(input logic signed [31:0] x);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd8388607;
    lo = -32'sd8388608;
    if (x > hi) begin
      sat24 = hi[FIELD_W-1:0];
    end else if (x < lo) begin
      sat24 = lo[FIELD_W-1:0];
    end else begin
      sat24 = x[FIELD_W-1:0];
    end
  endfunction

endpackage

@@ rtl/particle_spring_cursor_step.sv @@
// Top level: config registers, front end, square root, divider, back end.
//
// Advances one particle by one frame per item. An item is taken whenever start
// is high and busy is low; busy is high only while reset is applied and in the
// cycle after, so one item per clock is sustained. Each item produces exactly
// one result, shown on the new_* ports for a single cycle with done high. On
// its way the item passes 3 front-end stages (offsets, squares and gain
// products, radius test), 6 square root stages, 4 divider stages for the
// distance-to-radius ratio and 6 back-end stages (ratio, two multiply stages
// with their rounding steps, velocity and position saturation). The receiver
// cannot stall, so results must be taken as they appear. Configuration writes
// are always ready and apply to items taken after the write; write only while
// no item is in flight.
module particle_spring_cursor_step (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [pcs_pkg::FIELD_W-1:0] pos_x,
  input  logic signed [pcs_pkg::FIELD_W-1:0] pos_y,
  input  logic signed [pcs_pkg::FIELD_W-1:0] vel_x,
  input  logic signed [pcs_pkg::FIELD_W-1:0] vel_y,
  input  logic signed [pcs_pkg::FIELD_W-1:0] home_x,
  input  logic signed [pcs_pkg::FIELD_W-1:0] home_y,
  input  logic signed [pcs_pkg::FIELD_W-1:0] cursor_x,
  input  logic signed [pcs_pkg::FIELD_W-1:0] cursor_y,
  output logic                               done,
  output logic signed [pcs_pkg::FIELD_W-1:0] new_pos_x,
  output logic signed [pcs_pkg::FIELD_W-1:0] new_pos_y,
  output logic signed [pcs_pkg::FIELD_W-1:0] new_vel_x,
  output logic signed [pcs_pkg::FIELD_W-1:0] new_vel_y,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pcs_pkg::*;

  // Configuration registers
  logic                cursor_attracts;
  logic [RADIUS_W-1:0] force_radius;
  logic [GAIN_W-1:0]   friction_gain;
  logic [GAIN_W-1:0]   spring_gain;
  logic                spring_on;

  logic accept;

  logic                 fe_valid;
  side_t                fe_side;
  logic [SQ_IN_W-1:0]   fe_rad;
  logic                 sq_valid;
  logic [SQ_OUT_W-1:0]  sq_root;
  logic                 dv_valid;
  logic [QUO_W-1:0]     dv_quo;

  side_t side_dly [MID_LAT];

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_attracts <= 1'b0;
      force_radius    <= RADIUS_W'(45);
      friction_gain   <= GAIN_W'(55706);
      spring_gain     <= GAIN_W'(7864);
      spring_on       <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ATTRACTS:    cursor_attracts <= cfg_data[0];
        CFG_RADIUS:      force_radius    <= cfg_data[RADIUS_W-1:0];
        CFG_FRICTION:    friction_gain   <= cfg_data;
        CFG_SPRING_GAIN: spring_gain     <= cfg_data;
        CFG_SPRING_ON:   spring_on       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pcs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .home_x        (home_x),
    .home_y        (home_y),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .force_radius  (force_radius),
    .friction_gain (friction_gain),
    .spring_gain   (spring_gain),
    .spring_on     (spring_on),
    .out_valid     (fe_valid),
    .side          (fe_side),
    .radicand      (fe_rad)
  );

  pcs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fe_valid),
    .radicand  (fe_rad),
    .out_valid (sq_valid),
    .root      (sq_root)
  );

  pcs_div u_div (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (sq_valid),
    .distance     (sq_root),
    .force_radius (force_radius),
    .out_valid    (dv_valid),
    .quo          (dv_quo)
  );

  // Item data delay matching the root and divider stages
  always_ff @(posedge clk) begin
    side_dly[0] <= fe_side;
    for (int k = 1; k < MID_LAT; k++) begin
      side_dly[k] <= side_dly[k-1];
    end
  end

  pcs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (dv_valid),
    .side            (side_dly[MID_LAT-1]),
    .quo             (dv_quo),
    .cursor_attracts (cursor_attracts),
    .out_valid       (done),
    .new_pos_x       (new_pos_x),
    .new_pos_y       (new_pos_y),
    .new_vel_x       (new_vel_x),
    .new_vel_y       (new_vel_y)
  );

  // No item taken while reset is applied
  a_busy_in_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // Pipeline flushed by reset
  a_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  // Front end valid follows an accepted item via the va and vb registers
  a_front_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 (fe_valid || $past(rst, 1) || $past(rst, 2)))
    else $error("front end lost an item");

endmodule

@@ rtl/pcs_front.sv @@
// Front end: offsets, squared distance, radius test, damping and spring terms.
module pcs_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic signed [pcs_pkg::FIELD_W-1:0] pos_x,
  input  logic signed [pcs_pkg::FIELD_W-1:0] pos_y,
  input  logic signed [pcs_pkg::FIELD_W-1:0] vel_x,
  input  logic signed [pcs_pkg::FIELD_W-1:0] vel_y,
  input  logic signed [pcs_pkg::FIELD_W-1:0] home_x,
  input  logic signed [pcs_pkg::FIELD_W-1:0] home_y,
  input  logic signed [pcs_pkg::FIELD_W-1:0] cursor_x,
  input  logic signed [pcs_pkg::FIELD_W-1:0] cursor_y,
  input  logic [pcs_pkg::RADIUS_W-1:0]       force_radius,
  input  logic [pcs_pkg::GAIN_W-1:0]         friction_gain,
  input  logic [pcs_pkg::GAIN_W-1:0]         spring_gain,
  input  logic                               spring_on,
  output logic                               out_valid,
  output pcs_pkg::side_t                     side,
  output logic [pcs_pkg::SQ_IN_W-1:0]        radicand
);
  import pcs_pkg::*;

  localparam int SQ_W = 2 * DIFF_W;
  localparam int VP_W = FIELD_W + GAIN_W + 1;
  localparam int SP_W = DIFF_W + GAIN_W + 1;
  localparam int LIM_W = RADIUS_W + 8;

  // Stage A: offsets
  logic                      va;
  logic signed [FIELD_W-1:0] pos_a [2];
  logic signed [FIELD_W-1:0] vel_a [2];
  logic signed [DIFF_W-1:0]  d_a   [2];
  logic signed [DIFF_W-1:0]  hp_a  [2];

  // Stage B: products
  logic                      vb;
  logic signed [FIELD_W-1:0] pos_b [2];
  logic signed [DIFF_W-1:0]  d_b   [2];
  logic signed [SQ_W-1:0]    sq_b  [2];
  logic signed [VP_W-1:0]    vp_b  [2];
  logic signed [SP_W-1:0]    sp_b  [2];

  // Squared radius limit, follows config
  logic [LIM_W-1:0]   lim;
  logic [2*LIM_W-1:0] lim_sq;

  // Stage C combinational terms
  logic [SQ_W-1:0]          s_sum;
  logic signed [VP_W-1:0]   v_rnd [2];
  logic signed [SP_W-1:0]   s_rnd [2];

  assign lim = {force_radius, 8'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    lim_sq <= lim * lim;
  end

  // Stage A
  always_ff @(posedge clk) begin
    pos_a[0] <= pos_x;
    pos_a[1] <= pos_y;
    vel_a[0] <= vel_x;
    vel_a[1] <= vel_y;
    d_a[0]   <= DIFF_W'(cursor_x) - DIFF_W'(pos_x);
    d_a[1]   <= DIFF_W'(cursor_y) - DIFF_W'(pos_y);
    hp_a[0]  <= DIFF_W'(home_x) - DIFF_W'(pos_x);
    hp_a[1]  <= DIFF_W'(home_y) - DIFF_W'(pos_y);
  end

  // Stage B
  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      pos_b[k] <= pos_a[k];
      d_b[k]   <= d_a[k];
      sq_b[k]  <= d_a[k] * d_a[k];
      vp_b[k]  <= vel_a[k] * $signed({1'b0, friction_gain});
      sp_b[k]  <= hp_a[k] * $signed({1'b0, spring_gain});
    end
  end

  // Stage C: sum, radius test and rounding
  always_comb begin
    s_sum = $unsigned(sq_b[0]) + $unsigned(sq_b[1]);
    for (int k = 0; k < 2; k++) begin
      v_rnd[k] = (vp_b[k] + VP_W'(32768)) >>> 16;
      s_rnd[k] = (sp_b[k] + SP_W'(32768)) >>> 16;
    end
  end

  always_ff @(posedge clk) begin
    side.in_radius <= s_sum < SQ_W'(lim_sq);
    side.pos_x  <= pos_b[0];
    side.pos_y  <= pos_b[1];
    side.d_x    <= d_b[0];
    side.d_y    <= d_b[1];
    side.v_x    <= v_rnd[0][DIFF_W-1:0];
    side.v_y    <= v_rnd[1][DIFF_W-1:0];
    side.spr_x  <= spring_on ? s_rnd[0][SPR_W-1:0] : '0;
    side.spr_y  <= spring_on ? s_rnd[1][SPR_W-1:0] : '0;
    radicand    <= s_sum[SQ_IN_W-1:0];
  end

endmodule

@@ rtl/pcs_sqrt.sv @@
// Pipelined integer square root, a few root bits per stage.
module pcs_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [pcs_pkg::SQ_IN_W-1:0]  radicand,
  output logic                         out_valid,
  output logic [pcs_pkg::SQ_OUT_W-1:0] root
);
  import pcs_pkg::*;

  localparam int REM_W = SQ_OUT_W + 3;

  // Stage registers
  logic                vld [SQ_STAGES];
  logic [SQ_IN_W-1:0]  rad [SQ_STAGES];
  logic [REM_W-1:0]    rem [SQ_STAGES];
  logic [SQ_OUT_W-1:0] rt  [SQ_STAGES];

  // Stage inputs and next values
  logic                vld_in [SQ_STAGES];
  logic [SQ_IN_W-1:0]  rad_in [SQ_STAGES];
  logic [REM_W-1:0]    rem_in [SQ_STAGES];
  logic [SQ_OUT_W-1:0] rt_in  [SQ_STAGES];
  logic [SQ_IN_W-1:0]  rad_next [SQ_STAGES];
  logic [REM_W-1:0]    rem_next [SQ_STAGES];
  logic [SQ_OUT_W-1:0] rt_next  [SQ_STAGES];

  always_comb begin
    vld_in[0] = in_valid;
    rad_in[0] = radicand;
    rem_in[0] = '0;
    rt_in[0]  = '0;
    for (int k = 1; k < SQ_STAGES; k++) begin
      vld_in[k] = vld[k-1];
      rad_in[k] = rad[k-1];
      rem_in[k] = rem[k-1];
      rt_in[k]  = rt[k-1];
    end
  end

  // One root bit per step: bring down two radicand bits, try 4*root+1
  always_comb begin
    logic [REM_W-1:0]    rm;
    logic [SQ_IN_W-1:0]  rd;
    logic [SQ_OUT_W-1:0] ro;
    logic [REM_W-1:0]    trial;
    for (int k = 0; k < SQ_STAGES; k++) begin
      rm = rem_in[k];
      rd = rad_in[k];
      ro = rt_in[k];
      for (int j = 0; j < SQ_STEPS; j++) begin
        rm    = {rm[REM_W-3:0], rd[SQ_IN_W-1 -: 2]};
        rd    = {rd[SQ_IN_W-3:0], 2'b00};
        trial = {1'b0, ro, 2'b01};
        if (rm >= trial) begin
          rm = rm - trial;
          ro = {ro[SQ_OUT_W-2:0], 1'b1};
        end else begin
          ro = {ro[SQ_OUT_W-2:0], 1'b0};
        end
      end
      rad_next[k] = rd;
      rem_next[k] = rm;
      rt_next[k]  = ro;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_in[k];
      end
      rad[k] <= rad_next[k];
      rem[k] <= rem_next[k];
      rt[k]  <= rt_next[k];
    end
  end

  assign out_valid = vld[SQ_STAGES-1];
  assign root      = rt[SQ_STAGES-1];

endmodule

@@ rtl/pcs_div.sv @@
// Pipelined restoring divider for distance*256 / radius.
module pcs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [pcs_pkg::SQ_OUT_W-1:0]  distance,
  input  logic [pcs_pkg::RADIUS_W-1:0]  force_radius,
  output logic                          out_valid,
  output logic [pcs_pkg::QUO_W-1:0]     quo
);
  import pcs_pkg::*;

  localparam int REM_W = RADIUS_W;

  logic             vld [DV_STAGES];
  logic [QUO_W-1:0] num [DV_STAGES];
  logic [REM_W-1:0] rem [DV_STAGES];
  logic [QUO_W-1:0] qt  [DV_STAGES];

  logic             vld_in [DV_STAGES];
  logic [QUO_W-1:0] num_in [DV_STAGES];
  logic [REM_W-1:0] rem_in [DV_STAGES];
  logic [QUO_W-1:0] qt_in  [DV_STAGES];
  logic [QUO_W-1:0] num_next [DV_STAGES];
  logic [REM_W-1:0] rem_next [DV_STAGES];
  logic [QUO_W-1:0] qt_next  [DV_STAGES];

  // Upper distance bits start the remainder; lower bits and eight zeros follow
  always_comb begin
    vld_in[0] = in_valid;
    rem_in[0] = distance[SQ_OUT_W-1 -: REM_W];
    num_in[0] = {distance[7:0], 8'd0};
    qt_in[0]  = '0;
    for (int k = 1; k < DV_STAGES; k++) begin
      vld_in[k] = vld[k-1];
      num_in[k] = num[k-1];
      rem_in[k] = rem[k-1];
      qt_in[k]  = qt[k-1];
    end
  end

  always_comb begin
    logic [REM_W:0]   rm;
    logic [QUO_W-1:0] nb;
    logic [QUO_W-1:0] qo;
    for (int k = 0; k < DV_STAGES; k++) begin
      rm = {1'b0, rem_in[k]};
      nb = num_in[k];
      qo = qt_in[k];
      for (int j = 0; j < DV_STEPS; j++) begin
        rm = {rm[REM_W-1:0], nb[QUO_W-1]};
        nb = {nb[QUO_W-2:0], 1'b0};
        if (rm >= {1'b0, force_radius}) begin
          rm = rm - {1'b0, force_radius};
          qo = {qo[QUO_W-2:0], 1'b1};
        end else begin
          qo = {qo[QUO_W-2:0], 1'b0};
        end
      end
      num_next[k] = nb;
      rem_next[k] = rm[REM_W-1:0];
      qt_next[k]  = qo;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DV_STAGES; k++) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_in[k];
      end
      num[k] <= num_next[k];
      rem[k] <= rem_next[k];
      qt[k]  <= qt_next[k];
    end
  end

  assign out_valid = vld[DV_STAGES-1];
  assign quo       = qt[DV_STAGES-1];

endmodule

@@ rtl/pcs_back.sv @@
// Back end: ratio, cursor force, acceleration, velocity and position update.
module pcs_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  pcs_pkg::side_t                     side,
  input  logic [pcs_pkg::QUO_W-1:0]          quo,
  input  logic                               cursor_attracts,
  output logic                               out_valid,
  output logic signed [pcs_pkg::FIELD_W-1:0] new_pos_x,
  output logic signed [pcs_pkg::FIELD_W-1:0] new_pos_y,
  output logic signed [pcs_pkg::FIELD_W-1:0] new_vel_x,
  output logic signed [pcs_pkg::FIELD_W-1:0] new_vel_y
);
  import pcs_pkg::*;

  localparam int P_W   = DIFF_W + RATIO_W;
  localparam int T_W   = P_W - 16;
  localparam int ACC_W = 28;
  localparam int M_W   = ACC_W + RATIO_W;
  localparam int U_W   = M_W - 16;
  localparam int NV_W  = 32;

  localparam logic signed [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);

  logic [5:0] vld;

  // Stage 1: ratio
  side_t                     side1;
  logic signed [RATIO_W-1:0] r1;
  // Stage 2: offset times ratio
  side_t                     side2;
  logic signed [RATIO_W-1:0] r2;
  logic signed [P_W-1:0]     p2 [2];
  // Stage 3: acceleration
  side_t                     side3;
  logic signed [RATIO_W-1:0] r3;
  logic signed [ACC_W-1:0]   a3 [2];
  // Stage 4: acceleration times ratio
  side_t                     side4;
  logic signed [M_W-1:0]     m4 [2];
  // Stage 5: new velocity
  logic signed [FIELD_W-1:0] pos5 [2];
  logic signed [FIELD_W-1:0] nv5  [2];

  logic signed [T_W-1:0]   t_c   [2];
  logic signed [ACC_W-1:0] f_c   [2];
  logic signed [SPR_W-1:0] spr_c [2];
  logic signed [DIFF_W-1:0] d_c  [2];
  logic signed [DIFF_W-1:0] v_c  [2];
  logic signed [U_W-1:0]   u_c   [2];
  logic signed [NV_W-1:0]  nv_c  [2];
  logic signed [NV_W-1:0]  np_c  [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], in_valid};
    end
  end

  // Stage 1: within the radius gives quotient - 1.0, outside gives 1.0
  always_ff @(posedge clk) begin
    side1 <= side;
    r1    <= side.in_radius ? $signed({2'b11, quo}) : RATIO_ONE;
  end

  // Stage 2
  always_ff @(posedge clk) begin
    side2 <= side1;
    r2    <= r1;
    p2[0] <= side1.d_x * r1;
    p2[1] <= side1.d_y * r1;
  end

  // Stage 3: cursor force by mode plus spring pull
  always_comb begin
    spr_c[0] = side2.spr_x;
    spr_c[1] = side2.spr_y;
    for (int k = 0; k < 2; k++) begin
      t_c[k] = T_W'((p2[k] + P_W'(32768)) >>> 16);
      if (!side2.in_radius) begin
        f_c[k] = '0;
      end else if (cursor_attracts) begin
        f_c[k] = ACC_W'(t_c[k]);
      end else begin
        f_c[k] = -ACC_W'(t_c[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    side3 <= side2;
    r3    <= r2;
    for (int k = 0; k < 2; k++) begin
      a3[k] <= f_c[k] + ACC_W'(spr_c[k]);
    end
  end

  // Stage 4
  always_ff @(posedge clk) begin
    side4 <= side3;
    for (int k = 0; k < 2; k++) begin
      m4[k] <= a3[k] * r3;
    end
  end

  // Stage 5: damped velocity plus scaled acceleration
  always_comb begin
    v_c[0] = side4.v_x;
    v_c[1] = side4.v_y;
    for (int k = 0; k < 2; k++) begin
      u_c[k]  = U_W'((m4[k] + M_W'(32768)) >>> 16);
      nv_c[k] = NV_W'(v_c[k]) + NV_W'(u_c[k]);
    end
  end

  always_ff @(posedge clk) begin
    pos5[0] <= side4.pos_x;
    pos5[1] <= side4.pos_y;
    for (int k = 0; k < 2; k++) begin
      nv5[k] <= sat24(nv_c[k]);
    end
  end

  // Stage 6: position update, output registers
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      np_c[k] = NV_W'(pos5[k]) + NV_W'(nv5[k]);
    end
  end

  always_ff @(posedge clk) begin
    new_pos_x <= sat24(np_c[0]);
    new_pos_y <= sat24(np_c[1]);
    new_vel_x <= nv5[0];
    new_vel_y <= nv5[1];
  end

  assign out_valid = vld[5];

  // Outside the radius the ratio is exactly one
  a_ratio_outside: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !side1.in_radius |-> r1 == RATIO_ONE)
    else $error("ratio not one outside radius");

  // Within the radius the ratio is negative
  a_ratio_inside: assert property (@(posedge clk) disable iff (rst)
    vld[0] && side1.in_radius |-> r1[RATIO_W-1])
    else $error("ratio not negative inside radius");

  // Stage offsets not within the radius carry no cursor force
  a_no_force: assert property (@(posedge clk) disable iff (rst)
    vld[1] && !side2.in_radius |-> f_c[0] == '0 && f_c[1] == '0)
    else $error("cursor force outside radius");

endmodule

@@ tb/particle_spring_cursor_step_test.sv @@
// Self-checking testbench for the particle spring/cursor step pipeline.
module particle_spring_cursor_step_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pcs_pkg::*;

  localparam logic signed [FIELD_W-1:0] F_MAX = 24'sh7FFFFF;
  localparam logic signed [FIELD_W-1:0] F_MIN = 24'sh800000;
  localparam logic [CFG_IDX_W-1:0] NO_SUCH_REG = 3'd7;
  localparam int ITEMS_PER_PHASE = 80;

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_x, pos_y, vel_x, vel_y;
    logic signed [FIELD_W-1:0] home_x, home_y, cursor_x, cursor_y;
  } particle_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y;
  } motion_t;

  typedef struct packed {
    logic                  attracts;
    logic [RADIUS_W-1:0]   radius;
    logic [GAIN_W-1:0]     friction;
    logic [GAIN_W-1:0]     spring;
    logic                  spring_on;
  } knobs_t;

  typedef struct packed {
    particle_t in;
    logic      typed;
    motion_t   want;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [FIELD_W-1:0] pos_x = 0, pos_y = 0, vel_x = 0, vel_y = 0;
  logic signed [FIELD_W-1:0] home_x = 0, home_y = 0, cursor_x = 0, cursor_y = 0;
  logic done;
  logic signed [FIELD_W-1:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  knobs_t    knobs;
  motion_t   pending_motion[$];
  dir_row_t  dir_rows[$];
  int        errors = 0;

  particle_spring_cursor_step dut (.*);

  always #4 clk = ~clk;

  initial begin
    #5ms;
    $display("particle_spring_cursor_step_test failed");
    $finish;
  end

  // Integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint round16(longint x);
    return (x + 32768) >>> 16;
  endfunction

  function automatic logic signed [FIELD_W-1:0] clamp24(longint x);
    if (x > longint'(F_MAX)) return F_MAX;
    if (x < longint'(F_MIN)) return F_MIN;
    return x[FIELD_W-1:0];
  endfunction

  // Next velocity and position of one particle under the current knobs
  function automatic motion_t advance_particle(particle_t p, knobs_t k);
    longint ps[2], ve[2], ho[2], cu[2], d[2], v[2], a[2], nv[2], np[2];
    longint r, t;
    longint unsigned s, lim, q;
    motion_t m;
    ps[0] = p.pos_x;    ps[1] = p.pos_y;
    ve[0] = p.vel_x;    ve[1] = p.vel_y;
    ho[0] = p.home_x;   ho[1] = p.home_y;
    cu[0] = p.cursor_x; cu[1] = p.cursor_y;
    r = 65536;
    for (int i = 0; i < 2; i++) begin
      v[i] = round16(ve[i] * longint'(k.friction));
      d[i] = cu[i] - ps[i];
      a[i] = 0;
    end
    s = d[0] * d[0] + d[1] * d[1];
    lim = longint'(k.radius) * 256;
    // cursor force only strictly within the radius
    if (s < lim * lim) begin
      q = root_floor(s);
      r = longint'((q * 256) / k.radius) - 65536;
      for (int i = 0; i < 2; i++) begin
        t = round16(d[i] * r);
        a[i] = k.attracts ? t : -t;
      end
    end
    if (k.spring_on) begin
      for (int i = 0; i < 2; i++) a[i] += round16(longint'(k.spring) * (ho[i] - ps[i]));
    end
    for (int i = 0; i < 2; i++) begin
      nv[i] = clamp24(v[i] + round16(a[i] * r));
      np[i] = clamp24(ps[i] + nv[i]);
    end
    m.new_pos_x = np[0][FIELD_W-1:0];
    m.new_pos_y = np[1][FIELD_W-1:0];
    m.new_vel_x = nv[0][FIELD_W-1:0];
    m.new_vel_y = nv[1][FIELD_W-1:0];
    return m;
  endfunction

  // Register write; junk above the register width must be dropped.
  // Leaves cfg_valid high, apply_knobs drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ATTRACTS:    knobs.attracts  = data[0];
      CFG_RADIUS:      knobs.radius    = data[RADIUS_W-1:0];
      CFG_FRICTION:    knobs.friction  = data;
      CFG_SPRING_GAIN: knobs.spring    = data;
      CFG_SPRING_ON:   knobs.spring_on = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_knobs(knobs_t k);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_ATTRACTS, {junk[15:1], k.attracts});
    write_reg(CFG_RADIUS, {junk[15:10], k.radius});
    write_reg(CFG_FRICTION, k.friction);
    write_reg(CFG_SPRING_GAIN, k.spring);
    write_reg(CFG_SPRING_ON, {junk[14:0], k.spring_on});
    write_reg(NO_SUCH_REG, CFG_DATA_W'($urandom));
    cfg_valid <= 0;
  endtask

  // Drive one item; called at a falling edge, returns at a falling edge
  task automatic send_item(particle_t p, logic typed, motion_t want);
    int gap, pick;
    {pos_x, pos_y, vel_x, vel_y, home_x, home_y, cursor_x, cursor_y} <= p;
    start <= 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    pending_motion.insert(pending_motion.size(), typed ? want : advance_particle(p, knobs));
    pick = $urandom_range(0, 99);
    if (pick < 55) gap = 0;
    else if (pick < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain;
    start <= 0;
    while (pending_motion.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic longint spread(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  // Mostly particles near the cursor with random content, some pure noise
  function automatic particle_t random_particle(knobs_t k);
    particle_t p;
    longint span;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 3) == 0) return p;
    span = (k.radius == 0) ? 4096 : longint'(k.radius) * 384;
    p.pos_x = FIELD_W'(spread(1 << 22));
    p.pos_y = FIELD_W'(spread(1 << 22));
    p.cursor_x = clamp24(p.pos_x + spread(span));
    p.cursor_y = clamp24(p.pos_y + spread(span));
    p.home_x = clamp24(p.pos_x + spread(1 << 16));
    p.home_y = clamp24(p.pos_y + spread(1 << 16));
    if ($urandom_range(0, 3) != 0) begin
      p.vel_x = FIELD_W'(spread(1 << 18));
      p.vel_y = FIELD_W'(spread(1 << 18));
    end
    return p;
  endfunction

  // Result checking
  task automatic check_field(string name, logic signed [FIELD_W-1:0] want,
                             logic signed [FIELD_W-1:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    motion_t m;
    if (!rst && done) begin
      if (pending_motion.size() == 0) begin
        errors++;
        $error("result with no item outstanding");
      end else begin
        m = pending_motion.pop_front();
        check_field("new_pos_x", m.new_pos_x, new_pos_x);
        check_field("new_pos_y", m.new_pos_y, new_pos_y);
        check_field("new_vel_x", m.new_vel_x, new_vel_x);
        check_field("new_vel_y", m.new_vel_y, new_vel_y);
      end
    end
  end

  // Directed rows: rows marked typed carry a hand-derived result
  task automatic add_row(particle_t p, logic typed = 0, motion_t want = '0);
    dir_row_t row;
    row.in = p;
    row.typed = typed;
    row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  initial begin
    knobs_t phases[$];
    knobs_t k;
    knobs = '{attracts: 0, radius: 45, friction: 55706, spring: 7864, spring_on: 1};

    // zero particle at the cursor stays put
    add_row('0, 1, '0);
    add_row({8{F_MAX}});
    add_row({8{F_MIN}});
    add_row({F_MIN, F_MIN, F_MIN, F_MIN, F_MAX, F_MAX, F_MAX, F_MAX});
    add_row({F_MAX, F_MAX, F_MAX, F_MAX, F_MIN, F_MIN, F_MIN, F_MIN});
    // distance equal to radius counts as outside, one below is within
    add_row({24'sd0, 24'sd0, 24'sd100, -24'sd100, 24'sd5000, 24'sd0, 24'sd11520, 24'sd0});
    add_row({24'sd0, 24'sd0, 24'sd100, -24'sd100, 24'sd5000, 24'sd0, 24'sd11519, 24'sd0});
    add_row({24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd11520});
    add_row({24'sd1000, -24'sd2000, -24'sd300, 24'sd700, 24'sd0, 24'sd0,
             24'sd3000, 24'sd1000});
    add_row({24'sd1000, -24'sd2000, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd1001, -24'sd2000});
    add_row({F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, F_MAX - 24'sd256, F_MIN + 24'sd256});
    add_row({-24'sd1, 24'sd1, -24'sd1, 24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1});

    // settings walked after the directed part, extremes among them
    phases.insert(phases.size(), '{1, 45, 55706, 7864, 1});
    phases.insert(phases.size(), '{0, 0, 55706, 7864, 1});
    phases.insert(phases.size(), '{1, 1, 65535, 65535, 1});
    phases.insert(phases.size(), '{0, 1023, 0, 0, 1});
    phases.insert(phases.size(), '{1, 1023, 65535, 0, 0});
    phases.insert(phases.size(), '{0, 45, 0, 65535, 0});
    phases.insert(phases.size(), '{1, 200, 32768, 1000, 1});
    phases.insert(phases.size(), '{0, 7, 65535, 65535, 1});
    phases.insert(phases.size(), '{1, 0, 0, 0, 0});
    phases.insert(phases.size(), '{0, 512, 12345, 54321, 1});
    phases.insert(phases.size(), '{1, 1023, 55706, 65535, 1});
    phases.insert(phases.size(), '{0, 1, 0, 65535, 0});
    phases.insert(phases.size(), '{1, 90, 60000, 20000, 1});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    foreach (dir_rows[i]) send_item(dir_rows[i].in, dir_rows[i].typed, dir_rows[i].want);
    drain();

    foreach (phases[i]) begin
      apply_knobs(phases[i]);
      k = phases[i];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(random_particle(k), 0, '0);
      drain();
    end

    repeat (25) @(posedge clk);
    if (pending_motion.size() != 0) begin
      errors++;
      $error("%0d results never arrived", pending_motion.size());
    end
    if (errors == 0) begin
      $display("particle_spring_cursor_step_test passed");
    end else begin
      $display("particle_spring_cursor_step_test failed");
    end
    $finish;
  end

endmodule
